FILE: hw/rtl/aqr_pkg.sv
// Package for the admission queue with registry: sizes, command and status codes.
// Used by the top level and the checker; depends on nothing.
`default_nettype none
package aqr_pkg;
	localparam int MaxEntries = 64;
	localparam int IdBits = 32;
	localparam int AddrBits = $clog2(MaxEntries);
	localparam int CountBits = $clog2(MaxEntries + 1);

	typedef logic [IdBits-1:0] id_t;
	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [CountBits-1:0] count_t;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_JOIN = 2'd2,
		CMD_EXIT = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_REGISTERED = 4'd0,
		ST_DUPLICATE = 4'd1,
		ST_REG_FULL = 4'd2,
		ST_REMOVED = 4'd3,
		ST_NOT_FOUND = 4'd4,
		ST_NOT_REGISTERED = 4'd5,
		ST_CAP_UNSET = 4'd6,
		ST_ALREADY_QUEUED = 4'd7,
		ST_ADDED_ACTIVE = 4'd8,
		ST_ADDED_WAITING = 4'd9,
		ST_WAITING_FULL = 4'd10,
		ST_EXITED = 4'd11,
		ST_NONE_ACTIVE = 4'd12
	} status_t;
endpackage
`default_nettype wire

FILE: hw/rtl/aqr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the registry and both queue stores.
`default_nettype none
module aqr_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/admission_queue_with_registry.sv
// Channel   | Signals                                        | Handshake
// command   | start, command, learner_id                     | start && !busy
// result    | done, status, exited_id, promoted_valid, ...   | done, one cycle
// config    | capacity_we, capacity_wdata                    | capacity_we
// Every store is scanned one entry per cycle through its RAM read port, and a join may
// walk the registry and both queues. Unregister shifts later registry entries down one
// at a time, reading each in S_SHRD and writing it back one place lower in S_SHWR.
// Reset clears all counts and pointers; no clearing pass is needed. Results cannot stall.
// Depends on aqr_pkg and aqr_ram.
`default_nettype none
module admission_queue_with_registry (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [1:0]      command,
	input  wire logic [31:0]     learner_id,
	input  wire logic            capacity_we,
	input  wire logic [6:0]      capacity_wdata,
	output logic                 done,
	output logic [3:0]           status,
	output logic [31:0]          exited_id,
	output logic                 promoted_valid,
	output logic [31:0]          promoted_id
);
	import aqr_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RSCAN = 9'b000000010,
		S_RCHK  = 9'b000000100,
		S_SHRD  = 9'b000001000,
		S_SHWR  = 9'b000010000,
		S_ASCAN = 9'b000100000,
		S_WSCAN = 9'b001000000,
		S_EXIT  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	id_t id_q;
	logic [6:0] cap_q;
	count_t reg_cnt_q, a_cnt_q, w_cnt_q, idx_q;
	addr_t a_head_q, a_tail_q, w_head_q, w_tail_q, pos_q;
	logic pend_q, found_q;
	status_t st_q;
	id_t ex_q, pr_q;
	logic pv_q;

	// One shared compare unit fed by whichever RAM is being scanned.
	logic r_we, a_we, w_we;
	addr_t r_waddr, a_waddr, w_waddr, r_raddr, a_raddr, w_raddr;
	id_t r_wdata, a_wdata, w_wdata, r_rdata, a_rdata, w_rdata, cmp_data;
	logic hit;

	aqr_ram #(.Width(IdBits), .Depth(MaxEntries)) u_reg (
		.clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_rdata));
	aqr_ram #(.Width(IdBits), .Depth(MaxEntries)) u_act (
		.clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata));
	aqr_ram #(.Width(IdBits), .Depth(MaxEntries)) u_wait (
		.clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata));

	always_comb begin
		case (state_q)
			S_ASCAN: cmp_data = a_rdata;
			S_WSCAN: cmp_data = w_rdata;
			default: cmp_data = r_rdata;
		endcase
	end
	assign hit = pend_q && (cmp_data == id_q);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = st_q;
	assign exited_id = ex_q;
	assign promoted_valid = pv_q;
	assign promoted_id = pr_q;

	logic cap_ok;
	assign cap_ok = (cap_q != 7'd0) && ({1'b0, cap_q} <= 8'(MaxEntries));

	always_comb begin
		r_raddr = idx_q[AddrBits-1:0];
		a_raddr = a_head_q + idx_q[AddrBits-1:0];
		w_raddr = w_head_q + idx_q[AddrBits-1:0];
		if (state_q == S_EXIT) begin
			a_raddr = a_head_q;
			w_raddr = w_head_q;
		end
		if (state_q == S_SHRD) begin
			r_raddr = pos_q + addr_t'(1);
		end
		r_we = 1'b0; r_waddr = reg_cnt_q[AddrBits-1:0]; r_wdata = id_q;
		a_we = 1'b0; a_waddr = a_tail_q; a_wdata = id_q;
		w_we = 1'b0; w_waddr = w_tail_q; w_wdata = id_q;
		if (state_q == S_SHWR) begin
			r_we = 1'b1; r_waddr = pos_q; r_wdata = r_rdata;
		end
		if (state_q == S_RCHK && cmd_q == CMD_REGISTER && !found_q
				&& reg_cnt_q < count_t'(MaxEntries)) begin
			r_we = 1'b1;
		end
		if (state_q == S_WSCAN && !hit && idx_q == w_cnt_q) begin
			a_we = a_cnt_q < count_t'(cap_q);
			w_we = !a_we && w_cnt_q < count_t'(MaxEntries);
		end
		if (state_q == S_EXIT && pend_q && a_cnt_q != '0 && w_cnt_q != '0) begin
			a_we = 1'b1; a_wdata = w_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= '0;
			reg_cnt_q <= '0;
			a_cnt_q <= '0; a_head_q <= '0; a_tail_q <= '0;
			w_cnt_q <= '0; w_head_q <= '0; w_tail_q <= '0;
			idx_q <= '0; pend_q <= 1'b0; found_q <= 1'b0; pos_q <= '0;
			cmd_q <= CMD_REGISTER; st_q <= ST_REGISTERED;
			ex_q <= '0; pr_q <= '0; pv_q <= 1'b0; id_q <= '0;
		end else begin
			if (capacity_we) begin
				cap_q <= capacity_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd_t'(command);
						id_q <= learner_id;
						idx_q <= '0;
						pend_q <= 1'b0;
						ex_q <= '0; pr_q <= '0; pv_q <= 1'b0;
						state_q <= (cmd_t'(command) == CMD_EXIT) ? S_EXIT : S_RSCAN;
					end
				end
				S_RSCAN: begin
					// Data for the entry before idx_q arrives this cycle.
					found_q <= hit;
					if (hit || idx_q >= reg_cnt_q) begin
						state_q <= S_RCHK;
					end else begin
						pend_q <= 1'b1;
						idx_q <= idx_q + count_t'(1);
					end
				end
				S_RCHK: begin
					pend_q <= 1'b0;
					pos_q <= AddrBits'(idx_q - count_t'(1));
					state_q <= S_DONE;
					case (cmd_q)
						CMD_REGISTER: begin
							if (found_q) st_q <= ST_DUPLICATE;
							else if (reg_cnt_q >= count_t'(MaxEntries)) st_q <= ST_REG_FULL;
							else begin
								st_q <= ST_REGISTERED;
								reg_cnt_q <= reg_cnt_q + count_t'(1);
							end
						end
						CMD_UNREGISTER: begin
							if (!found_q) st_q <= ST_NOT_FOUND;
							else begin
								st_q <= ST_REMOVED;
								state_q <= S_SHRD;
							end
						end
						default: begin
							if (!found_q) st_q <= ST_NOT_REGISTERED;
							else if (!cap_ok) st_q <= ST_CAP_UNSET;
							else begin
								idx_q <= '0;
								state_q <= S_ASCAN;
							end
						end
					endcase
				end
				S_SHRD: begin
					if (count_t'(pos_q) + count_t'(1) >= reg_cnt_q) begin
						reg_cnt_q <= reg_cnt_q - count_t'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					pos_q <= pos_q + addr_t'(1);
					state_q <= S_SHRD;
				end
				S_ASCAN: begin
					if (hit) begin
						st_q <= ST_ALREADY_QUEUED;
						state_q <= S_DONE;
					end else if (idx_q >= a_cnt_q) begin
						idx_q <= '0;
						pend_q <= 1'b0;
						state_q <= S_WSCAN;
					end else begin
						pend_q <= 1'b1;
						idx_q <= idx_q + count_t'(1);
					end
				end
				S_WSCAN: begin
					if (hit) begin
						st_q <= ST_ALREADY_QUEUED;
						state_q <= S_DONE;
					end else if (idx_q >= w_cnt_q) begin
						state_q <= S_DONE;
						if (a_cnt_q < count_t'(cap_q)) begin
							st_q <= ST_ADDED_ACTIVE;
							a_tail_q <= a_tail_q + addr_t'(1);
							a_cnt_q <= a_cnt_q + count_t'(1);
						end else if (w_cnt_q < count_t'(MaxEntries)) begin
							st_q <= ST_ADDED_WAITING;
							w_tail_q <= w_tail_q + addr_t'(1);
							w_cnt_q <= w_cnt_q + count_t'(1);
						end else begin
							st_q <= ST_WAITING_FULL;
						end
					end else begin
						pend_q <= 1'b1;
						idx_q <= idx_q + count_t'(1);
					end
				end
				S_EXIT: begin
					// Read data on entry may come from a stale scan address; use it once pend_q is set.
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						state_q <= S_DONE;
						if (a_cnt_q == '0) begin
							st_q <= ST_NONE_ACTIVE;
						end else begin
							st_q <= ST_EXITED;
							ex_q <= a_rdata;
							a_head_q <= a_head_q + addr_t'(1);
							if (w_cnt_q != '0) begin
								pv_q <= 1'b1;
								pr_q <= w_rdata;
								w_head_q <= w_head_q + addr_t'(1);
								w_cnt_q <= w_cnt_q - count_t'(1);
								a_tail_q <= a_tail_q + addr_t'(1);
							end else begin
								a_cnt_q <= a_cnt_q - count_t'(1);
							end
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/aqr_checker.sv
// Port-level checker for admission_queue_with_registry, bound to the top level.
// Depends on aqr_pkg for the status codes.
`default_nettype none
module aqr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [3:0]  status,
	input wire logic [31:0] exited_id,
	input wire logic        promoted_valid,
	input wire logic [31:0] promoted_id
);
	import aqr_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command did not raise busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result outside a command");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
	a_prom: assert property (@(posedge clk) disable iff (!arst_n)
		done && promoted_valid |-> status == ST_EXITED)
		else $error("promotion without exit");
	a_exit0: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_EXITED |-> exited_id == '0 && promoted_id == '0)
		else $error("ID fields not zero");
endmodule

bind admission_queue_with_registry aqr_checker u_aqr_checker (
	.clk, .arst_n, .start, .busy, .done, .status, .exited_id, .promoted_valid, .promoted_id);
`default_nettype wire
